// ===== hdl/clr_pkg.sv =====
// shared types, constants and helpers of the clipped line rasterizer
`default_nettype none
package clr_pkg;

	// coordinate and arithmetic widths
	localparam int CoordW   = 18;
	localparam int ProdW    = 2 * CoordW;
	localparam int QuotW    = 18;
	localparam int FracBits = 16;
	localparam int FractW   = 24;
	localparam int SizeW    = 7;
	localparam int PixW     = 6;
	localparam int ColorW   = 8;
	localparam int CfgIdxW  = 2;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CfgViewWidth  = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgViewHeight = 2'd1;

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic signed [ProdW-1:0]  prod_t;
	typedef logic signed [QuotW:0]    quot_t;
	typedef logic signed [FractW-1:0] fract_t;

	// one classified segment, handed from front to back
	typedef struct packed {
		logic [PixW-1:0]   x1;
		logic [PixW-1:0]   y1;
		logic [PixW-1:0]   x2;
		logic [PixW-1:0]   y2;
		logic              x_major;
		logic              dup;
		coord_t            step;
		logic [ColorW-1:0] color;
	} job_t;

	typedef enum logic [7:0] {
		F_IDLE  = 8'b00000001,
		F_PICK  = 8'b00000010,
		F_DIVST = 8'b00000100,
		F_DIVW  = 8'b00001000,
		F_CHECK = 8'b00010000,
		F_STEP  = 8'b00100000,
		F_STEPW = 8'b01000000,
		F_PUSH  = 8'b10000000
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_RUN  = 2'b10
	} back_state_t;

	// clamp a coordinate into 0 .. size-1
	function automatic logic [PixW-1:0] clamp_pix(coord_t c, logic [SizeW-1:0] size);
		logic [SizeW-1:0] top;
		top = size - 7'd1;
		if (c < 0)
			return '0;
		else if (c >= coord_t'({1'b0, size}))
			return top[PixW-1:0];
		else
			return c[PixW-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/clipped_line_rasterizer.sv =====
// top level of the clipped line rasterizer
//
// channel   direction  handshake            payload
// segment   in         push / full          start_x start_y end_x end_y pen_color
// pixel     out        empty / pop          pixel_x pixel_y pixel_color last_pixel
// config    in         cfg_valid/cfg_ready  cfg_index cfg_data
//
// the front takes one segment at a time: each active clip edge costs one run of
// the shared serial divider (18 quotient bits), and the step division another.
// the back then writes one pixel per cycle unless the pixel output stalls,
// up to 64 per segment, behind a two-entry segment queue, so front and back
// overlap on consecutive segments. reset is asynchronous, active low; there is
// no clearing pass. a stalled pixel output halts the back, and the front too
// once the segment queue is full; config is always ready.
`default_nettype none
module clipped_line_rasterizer #(
	parameter int MAX_VIEW_SIZE = 64
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          push,
	output logic                         full,
	input  wire signed [15:0]            start_x,
	input  wire signed [15:0]            start_y,
	input  wire signed [15:0]            end_x,
	input  wire signed [15:0]            end_y,
	input  wire [7:0]                    pen_color,
	output logic                         empty,
	input  wire                          pop,
	output logic [5:0]                   pixel_x,
	output logic [5:0]                   pixel_y,
	output logic [7:0]                   pixel_color,
	output logic                         last_pixel,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire [clr_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire [clr_pkg::SizeW-1:0]     cfg_data
);
	import clr_pkg::*;

	localparam logic [SizeW-1:0] MaxSize = SizeW'(MAX_VIEW_SIZE);
	localparam logic [SizeW-1:0] RstSize = (MAX_VIEW_SIZE < 64) ? SizeW'(MAX_VIEW_SIZE) : 7'd64;

	logic [SizeW-1:0] width_q, height_q, cfg_sat;
	job_t             f_job, b_job;
	logic             f_push, q_full, q_empty, b_pop;

	// register write with saturation into 1 .. max
	assign cfg_ready = 1'b1;
	assign cfg_sat   = (cfg_data == '0) ? 7'd1 : ((cfg_data > MaxSize) ? MaxSize : cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RstSize;
			height_q <= RstSize;
		end else if (cfg_valid) begin
			case (cfg_index)
				CfgViewWidth:  width_q  <= cfg_sat;
				CfgViewHeight: height_q <= cfg_sat;
				default: ;
			endcase
		end
	end

	clr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.pen_color (pen_color),
		.view_w    (width_q),
		.view_h    (height_q),
		.job       (f_job),
		.job_push  (f_push),
		.job_full  (q_full)
	);

	clr_job_fifo u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (f_push),
		.wr_job (f_job),
		.full   (q_full),
		.rd     (b_pop),
		.rd_job (b_job),
		.empty  (q_empty)
	);

	clr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job         (b_job),
		.job_empty   (q_empty),
		.job_pop     (b_pop),
		.view_w      (width_q),
		.view_h      (height_q),
		.empty       (empty),
		.pop         (pop),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last_pixel  (last_pixel)
	);

endmodule
`default_nettype wire

// ===== hdl/clr_divider.sv =====
// serial signed divider, truncating toward zero, one quotient bit per cycle
`default_nettype none
module clr_divider (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  clr_pkg::prod_t   num,
	input  clr_pkg::coord_t  den,
	output logic             done,
	output clr_pkg::quot_t   quot
);
	import clr_pkg::*;

	logic [QuotW-1:0]  rem_q;
	logic [QuotW-1:0]  lo_q;
	logic [CoordW-1:0] den_q;
	logic              neg_q;
	logic              zero_q;
	logic              busy_q;
	logic              done_q;
	logic [4:0]        cnt_q;
	logic [ProdW-1:0]  num_mag;
	logic [CoordW-1:0] den_mag;
	logic [QuotW:0]    trial;
	logic [QuotW:0]    diff;
	logic              ge;

	// operand magnitudes
	assign num_mag = num[ProdW-1] ? ProdW'(-num) : ProdW'(num);
	assign den_mag = den[CoordW-1] ? CoordW'(-den) : CoordW'(den);

	// one restoring step
	assign trial = {rem_q, lo_q[QuotW-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(QuotW - 1);
			end else if (busy_q) begin
				if (cnt_q == 5'd0)
					busy_q <= 1'b0;
				else
					cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num_mag[ProdW-1:QuotW];
			lo_q   <= num_mag[QuotW-1:0];
			den_q  <= den_mag;
			neg_q  <= num[ProdW-1] ^ den[CoordW-1];
			zero_q <= (den == '0);
		end else if (busy_q) begin
			rem_q <= ge ? diff[QuotW-1:0] : trial[QuotW-1:0];
			lo_q  <= {lo_q[QuotW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = zero_q ? '0 : (neg_q ? -quot_t'({1'b0, lo_q}) : quot_t'({1'b0, lo_q}));

endmodule
`default_nettype wire

// ===== hdl/clr_front.sv =====
// front: accepts segments, clips them edge by edge and works out the dda step
`default_nettype none
module clr_front (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          push,
	output logic                         full,
	input  wire signed [15:0]            start_x,
	input  wire signed [15:0]            start_y,
	input  wire signed [15:0]            end_x,
	input  wire signed [15:0]            end_y,
	input  wire [7:0]                    pen_color,
	input  wire [clr_pkg::SizeW-1:0]     view_w,
	input  wire [clr_pkg::SizeW-1:0]     view_h,
	output clr_pkg::job_t                job,
	output logic                         job_push,
	input  wire                          job_full
);
	import clr_pkg::*;

	front_state_t      state_q;
	logic [2:0]        k_q;
	coord_t            x1_q, y1_q, x2_q, y2_q;
	coord_t            dx0_q, dy0_q;
	coord_t            ndx_q, ndy_q;
	coord_t            den_s1;
	prod_t             prod_s1;
	coord_t            step_q;
	logic              xmaj_q;
	logic [ColorW-1:0] color_q;

	logic              on_y, ep2, low_edge, cond;
	logic [SizeW-1:0]  size;
	coord_t            bnd, c, o, off, mul, den_c, q;
	prod_t             prod_c;
	coord_t            wc, hc, sx, sy;
	logic              reject, xmaj_c;
	logic              div_start, div_done;
	prod_t             div_num;
	coord_t            div_den;
	quot_t             div_quot;
	coord_t            sx0, sy0, ex0, ey0;

	// clip edge selection: left, right, bottom, top, each for both endpoints
	assign on_y     = k_q[2];
	assign ep2      = k_q[0];
	assign low_edge = ~(k_q[1] ^ k_q[2]);
	assign size     = on_y ? view_h : view_w;
	assign bnd      = low_edge ? '0 : coord_t'({1'b0, size}) - coord_t'(1);
	assign c        = on_y ? (ep2 ? y2_q : y1_q) : (ep2 ? x2_q : x1_q);
	assign o        = on_y ? (ep2 ? y1_q : y2_q) : (ep2 ? x1_q : x2_q);
	assign cond     = low_edge ? (c < 0 && o >= 0) : (c > bnd && o <= bnd);
	assign off      = bnd - c;
	assign mul      = on_y ? dx0_q : dy0_q;
	assign den_c    = on_y ? dy0_q : dx0_q;
	assign prod_c   = prod_t'(off) * prod_t'(mul);
	assign q        = coord_t'(div_quot);

	// outside test and major axis
	assign wc     = coord_t'({1'b0, view_w});
	assign hc     = coord_t'({1'b0, view_h});
	assign reject = (x1_q >= wc && x2_q >= wc) || (x1_q < 0 && x2_q < 0) ||
			(y1_q >= hc && y2_q >= hc) || (y1_q < 0 && y2_q < 0);
	assign sx     = ndx_q[CoordW-1] ? -ndx_q : ndx_q;
	assign sy     = ndy_q[CoordW-1] ? -ndy_q : ndy_q;
	assign xmaj_c = sx > sy;

	// shared divider operands
	assign div_start = (state_q == F_DIVST) || (state_q == F_STEP);
	assign div_num   = (state_q == F_STEP) ?
			((xmaj_c ? prod_t'(ndy_q) : prod_t'(ndx_q)) <<< FracBits) : prod_s1;
	assign div_den   = (state_q == F_STEP) ? (xmaj_c ? ndx_q : ndy_q) : den_s1;

	clr_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign sx0 = coord_t'(start_x);
	assign sy0 = coord_t'(start_y);
	assign ex0 = coord_t'(end_x);
	assign ey0 = coord_t'(end_y);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			k_q     <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (push) begin
						state_q <= F_PICK;
						k_q     <= '0;
					end
				end
				F_PICK: begin
					if (cond)
						state_q <= F_DIVST;
					else if (k_q == 3'd7)
						state_q <= F_CHECK;
					else
						k_q <= k_q + 3'd1;
				end
				F_DIVST: state_q <= F_DIVW;
				F_DIVW: begin
					if (div_done) begin
						if (k_q == 3'd7) begin
							state_q <= F_CHECK;
						end else begin
							state_q <= F_PICK;
							k_q     <= k_q + 3'd1;
						end
					end
				end
				F_CHECK: state_q <= reject ? F_IDLE : F_STEP;
				F_STEP:  state_q <= F_STEPW;
				F_STEPW: begin
					if (div_done)
						state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!job_full)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// coordinate datapath
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && push) begin
			x1_q    <= sx0;
			y1_q    <= sy0;
			x2_q    <= ex0;
			y2_q    <= ey0;
			dx0_q   <= ex0 - sx0;
			dy0_q   <= ey0 - sy0;
			color_q <= pen_color;
		end
		if (state_q == F_PICK) begin
			prod_s1 <= prod_c;
			den_s1  <= den_c;
		end
		if (state_q == F_DIVW && div_done) begin
			if (on_y) begin
				if (ep2) begin
					x2_q <= x2_q + q;
					y2_q <= bnd;
				end else begin
					x1_q <= x1_q + q;
					y1_q <= bnd;
				end
			end else begin
				if (ep2) begin
					y2_q <= y2_q + q;
					x2_q <= bnd;
				end else begin
					y1_q <= y1_q + q;
					x1_q <= bnd;
				end
			end
		end
		if (state_q == F_CHECK) begin
			ndx_q <= x2_q - x1_q;
			ndy_q <= y2_q - y1_q;
		end
		if (state_q == F_STEP)
			xmaj_q <= xmaj_c;
		if (state_q == F_STEPW && div_done)
			step_q <= q;
	end

	// job handoff
	assign full          = (state_q != F_IDLE);
	assign job_push      = (state_q == F_PUSH) && !job_full;
	assign job.x1        = clamp_pix(x1_q, view_w);
	assign job.y1        = clamp_pix(y1_q, view_h);
	assign job.x2        = clamp_pix(x2_q, view_w);
	assign job.y2        = clamp_pix(y2_q, view_h);
	assign job.x_major   = xmaj_q;
	assign job.dup       = (ndx_q == '0) && (ndy_q == '0);
	assign job.step      = step_q;
	assign job.color     = color_q;

endmodule
`default_nettype wire

// ===== hdl/clr_job_fifo.sv =====
// two-entry queue of classified segments between front and back
`default_nettype none
module clr_job_fifo (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            wr,
	input  clr_pkg::job_t  wr_job,
	output logic           full,
	input  wire            rd,
	output clr_pkg::job_t  rd_job,
	output logic           empty
);
	import clr_pkg::*;

	job_t       mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign full   = (cnt_q == 2'd2);
	assign empty  = (cnt_q == 2'd0);
	assign rd_job = mem_q[rptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (wr)
				wptr_q <= ~wptr_q;
			if (rd)
				rptr_q <= ~rptr_q;
			if (wr && !rd)
				cnt_q <= cnt_q + 2'd1;
			else if (rd && !wr)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wptr_q] <= wr_job;
	end

endmodule
`default_nettype wire

// ===== hdl/clr_back.sv =====
// back: steps the dda along the major axis, one pixel per cycle unless the pixel output stalls
`default_nettype none
module clr_back (
	input  wire                          clk,
	input  wire                          arst_n,
	input  clr_pkg::job_t                job,
	input  wire                          job_empty,
	output logic                         job_pop,
	input  wire [clr_pkg::SizeW-1:0]     view_w,
	input  wire [clr_pkg::SizeW-1:0]     view_h,
	output logic                         empty,
	input  wire                          pop,
	output logic [5:0]                   pixel_x,
	output logic [5:0]                   pixel_y,
	output logic [7:0]                   pixel_color,
	output logic                         last_pixel
);
	import clr_pkg::*;

	back_state_t       state_q;
	logic [PixW-1:0]   a_q, b_q;
	logic              up_q, xmaj_q, dup_q;
	coord_t            step_q;
	fract_t            fract_q;
	logic [ColorW-1:0] color_q;
	logic              ovalid_q;
	logic [PixW-1:0]   px_q, py_q;
	logic [ColorW-1:0] pc_q;
	logic              last_q;

	logic [SizeW-1:0]  msize, mtop;
	fract_t            fc, stepx;
	logic [PixW-1:0]   minor, mstart;
	logic              adv, is_last;

	// minor axis clamp
	assign msize  = xmaj_q ? view_h : view_w;
	assign mtop   = msize - 7'd1;
	assign fc     = fract_q[FractW-1] ? '0 :
			(fract_q[FracBits+SizeW-1:FracBits] >= msize ?
			 fract_t'({mtop, {FracBits{1'b0}}}) : fract_q);
	assign minor  = fc[FracBits+PixW-1:FracBits];
	assign stepx  = fract_t'(step_q);
	assign is_last = !dup_q && (a_q == b_q);
	assign adv    = (state_q == B_RUN) && (!ovalid_q || pop);
	assign mstart = job.x_major ? job.y1 : job.x1;

	assign job_pop = (state_q == B_IDLE) && !job_empty;

	// stepping control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (!job_empty)
						state_q <= B_RUN;
				end
				B_RUN: begin
					if (adv && is_last)
						state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
			if (adv)
				ovalid_q <= 1'b1;
			else if (pop)
				ovalid_q <= 1'b0;
		end
	end

	// dda datapath
	always_ff @(posedge clk) begin
		if (job_pop) begin
			a_q     <= job.x_major ? job.x1 : job.y1;
			b_q     <= job.x_major ? job.x2 : job.y2;
			up_q    <= job.x_major ? (job.x1 < job.x2) : (job.y1 < job.y2);
			xmaj_q  <= job.x_major;
			dup_q   <= job.dup;
			step_q  <= job.step;
			color_q <= job.color;
			fract_q <= fract_t'({mstart, {FracBits{1'b0}}});
		end else if (adv) begin
			if (dup_q) begin
				dup_q <= 1'b0;
			end else begin
				fract_q <= up_q ? fc + stepx : fc - stepx;
				a_q     <= up_q ? a_q + 6'd1 : a_q - 6'd1;
			end
		end
		if (adv) begin
			px_q   <= xmaj_q ? a_q : minor;
			py_q   <= xmaj_q ? minor : a_q;
			pc_q   <= color_q;
			last_q <= is_last;
		end
	end

	assign empty       = !ovalid_q;
	assign pixel_x     = px_q;
	assign pixel_y     = py_q;
	assign pixel_color = pc_q;
	assign last_pixel  = last_q;

endmodule
`default_nettype wire
